>>> design/cbm_pkg.sv
package cbm_pkg;

    // Widest store index: four banks of 8 KiB
    localparam int RAM_IDX_W   = 15;
    localparam int BANK_OFF_W  = 13;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_BANK_W  = 7;
    localparam int ROM_OFF_W   = 14;

    typedef enum logic [1:0] {
        REQ_ROM_READ = 2'd0,
        REQ_RAM_READ = 2'd1,
        REQ_WRITE    = 2'd2,
        REQ_NOP      = 2'd3
    } req_type_t;

    // Address regions, decoded from address[15:13]
    localparam logic [2:0] REGION_ENABLE    = 3'd0;  // 0x0000-0x1FFF
    localparam logic [2:0] REGION_BANK_LOW  = 3'd1;  // 0x2000-0x3FFF
    localparam logic [2:0] REGION_BANK_HIGH = 3'd2;  // 0x4000-0x5FFF
    localparam logic [2:0] REGION_MODE      = 3'd3;  // 0x6000-0x7FFF
    localparam logic [2:0] REGION_RAM       = 3'd5;  // 0xA000-0xBFFF

    localparam logic [7:0] ENABLE_MASK = 8'h0A;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [RAM_IDX_W-1:0] addr;
        logic [7:0]           wdata;
    } mem_req_t;

    typedef struct packed {
        logic                  ram_read;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  ram_enabled_status;
        logic                  ram_dirty;
    } stage_t;

endpackage

>>> design/cbm_ifs.sv
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [20:0] rom_address;
    logic        ram_enabled_status;
    logic        ram_dirty;

    modport source (output valid, output read_data, output rom_address,
                    output ram_enabled_status, output ram_dirty, input ready);
    modport sink   (input valid, input read_data, input rom_address,
                    input ram_enabled_status, input ram_dirty, output ready);
endinterface

interface cbm_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/cartridge_bank_mapper.sv
// A word accepted on req passes the stage and output registers; throughput is one word
// per cycle while rsp takes results. The single-port RAM store serves one read or one
// write per accepted word, and bank registers update in the cycle they are written.
// Reset: rst_n (asynchronous, active low) clears the bank registers, the RAM enable
// and dirty flags, sets the ROM bank to 1 and marks external RAM present.
// The RAM store keeps no reset; contents are undefined until written.
module cartridge_bank_mapper #(
    parameter int RAM_BANK_COUNT = 4,
    parameter int ROM_BANK_LIMIT = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    cbm_req_if.sink    req,
    cbm_rsp_if.source  rsp,
    cbm_cfg_if.sink    cfg
);
    import cbm_pkg::*;

    // RAM store holds RAM_BANK_COUNT banks of 8 KiB
    localparam int STORE_BYTES = RAM_BANK_COUNT * (2 ** BANK_OFF_W);

    mem_req_t   mem_req;
    stage_t     stage;
    logic [7:0] rdata;
    logic       req_ready;
    logic       accept;

    // Take a word whenever the first pipeline stage is free or drains this cycle
    assign req.ready = req_ready;
    assign accept    = req.valid && req_ready;

    // Decode the access, update the bank registers and issue the store access
    cbm_ctrl #(
        .RAM_BANK_COUNT (RAM_BANK_COUNT),
        .ROM_BANK_LIMIT (ROM_BANK_LIMIT)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cfg     (cfg),
        .accept  (accept),
        .mem_req (mem_req),
        .stage   (stage)
    );

    // RAM store: one access per cycle, registered read data. A write and a
    // later read of the same byte never overlap, since each lands at its own
    // accept edge and the read samples the array after the write has landed.
    cbm_ram #(
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // Hold the in-flight word beside the store read, then the output word;
    // the output register lets a new word in while a result waits.
    cbm_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .stage     (stage),
        .rdata     (rdata),
        .req_ready (req_ready),
        .rsp       (rsp)
    );

endmodule

>>> design/cbm_ram.sv
module cbm_ram #(
    parameter int DEPTH = 32768
) (
    input  logic               clk,
    input  cbm_pkg::mem_req_t  mem_req,
    output logic [7:0]         rdata
);
    import cbm_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.addr[IDX_W-1:0]] <= mem_req.wdata;
        end
        // hold read data until the next read
        if (mem_req.rd_en)
        begin
            rdata_reg <= mem[mem_req.addr[IDX_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cbm_ctrl.sv
module cbm_ctrl #(
    parameter int RAM_BANK_COUNT = 4,
    parameter int ROM_BANK_LIMIT = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    cbm_req_if.sink            req,
    cbm_cfg_if.sink            cfg,
    input  logic               accept,
    output cbm_pkg::mem_req_t  mem_req,
    output cbm_pkg::stage_t    stage
);
    import cbm_pkg::*;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_MAX = ROM_BANK_W'(ROM_BANK_LIMIT - 1);
    localparam logic [2:0]            BANK_COUNT   = 3'(RAM_BANK_COUNT);

    logic                  ram_present_reg;
    logic                  ram_enable_reg, ram_enable_next;
    logic                  bank_mode_reg, bank_mode_next;
    logic [4:0]            bank_low_reg, bank_low_next;
    logic [1:0]            bank_high_reg, bank_high_next;
    logic [ROM_BANK_W-1:0] rom_bank_sel_reg, rom_bank_sel_next;
    logic [1:0]            ram_bank_sel_reg, ram_bank_sel_next;
    logic                  dirty_reg, dirty_next;

    logic [2:0]            region;
    logic                  in_ram;
    logic                  is_write;
    logic                  is_rom_read;
    logic                  is_ram_read;
    logic                  recompute;
    logic [2:0]            bank_mod;
    logic [ROM_BANK_W-1:0] rom_bank;

    assign cfg.ready   = 1'b1;
    assign region      = req.address[15:13];
    assign in_ram      = (region == REGION_RAM);
    assign is_write    = accept && (req.req_type == REQ_WRITE);
    assign is_rom_read = (req.req_type == REQ_ROM_READ);
    assign is_ram_read = (req.req_type == REQ_RAM_READ) && in_ram;

    always_comb
    begin
        ram_enable_next   = ram_enable_reg;
        bank_mode_next    = bank_mode_reg;
        bank_low_next     = bank_low_reg;
        bank_high_next    = bank_high_reg;
        rom_bank_sel_next = rom_bank_sel_reg;
        ram_bank_sel_next = ram_bank_sel_reg;
        dirty_next        = dirty_reg;
        recompute         = 1'b0;
        if (is_write)
        begin
            unique case (region)
                REGION_ENABLE:
                begin
                    ram_enable_next = |(req.write_data & ENABLE_MASK);
                end
                REGION_BANK_LOW:
                begin
                    bank_low_next = req.write_data[4:0];
                    recompute     = 1'b1;
                end
                REGION_BANK_HIGH:
                begin
                    bank_high_next = req.write_data[1:0];
                    recompute      = 1'b1;
                end
                REGION_MODE:
                begin
                    // mode write also clears the high bank
                    bank_mode_next = |req.write_data;
                    bank_high_next = 2'd0;
                    recompute      = 1'b1;
                end
                REGION_RAM:
                begin
                    dirty_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (recompute)
        begin
            // banks with a zero low part move up by one
            rom_bank_sel_next = {bank_mode_next ? 2'd0 : bank_high_next,
                                 (bank_low_next == 5'd0) ? 5'd1 : bank_low_next};
            ram_bank_sel_next = bank_mode_next ? bank_high_next : 2'd0;
        end
    end

    // wrap the RAM bank to the fitted bank count
    always_comb
    begin
        bank_mod = {1'b0, ram_bank_sel_reg};
        for (int i = 0; i < 3; i++)
        begin
            if (bank_mod >= BANK_COUNT)
            begin
                bank_mod = bank_mod - BANK_COUNT;
            end
        end
    end

    assign rom_bank = (rom_bank_sel_reg > ROM_BANK_MAX) ? ROM_BANK_MAX : rom_bank_sel_reg;

    always_comb
    begin
        mem_req.rd_en = accept && is_ram_read;
        mem_req.wr_en = is_write && in_ram;
        mem_req.addr  = {ram_enable_reg ? bank_mod[1:0] : 2'd0,
                         req.address[BANK_OFF_W-1:0]};
        mem_req.wdata = req.write_data;

        stage.ram_read           = is_ram_read;
        stage.rom_address        = is_rom_read
                                 ? ROM_ADDR_W'(req.address)
                                   + {rom_bank - ROM_BANK_W'(1), ROM_OFF_W'(0)}
                                 : ROM_ADDR_W'(0);
        stage.ram_enabled_status = ram_enable_next & ram_present_reg;
        stage.ram_dirty          = dirty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_present_reg  <= 1'b1;
            ram_enable_reg   <= 1'b0;
            bank_mode_reg    <= 1'b0;
            bank_low_reg     <= 5'd0;
            bank_high_reg    <= 2'd0;
            rom_bank_sel_reg <= ROM_BANK_W'(1);
            ram_bank_sel_reg <= 2'd0;
            dirty_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                ram_present_reg <= cfg.data;
            end
            ram_enable_reg   <= ram_enable_next;
            bank_mode_reg    <= bank_mode_next;
            bank_low_reg     <= bank_low_next;
            bank_high_reg    <= bank_high_next;
            rom_bank_sel_reg <= rom_bank_sel_next;
            ram_bank_sel_reg <= ram_bank_sel_next;
            dirty_reg        <= dirty_next;
        end
    end

endmodule

>>> design/cbm_pipe.sv
module cbm_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  cbm_pkg::stage_t  stage,
    input  logic [7:0]       rdata,
    output logic             req_ready,
    cbm_rsp_if.source        rsp
);
    import cbm_pkg::*;

    logic   s1_valid_reg;
    stage_t s1_reg;
    logic   out_valid_reg;
    logic [7:0] out_read_data_reg;
    stage_t out_reg;
    logic   out_free;
    logic   s1_move;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
        // memory word lines up with its item here
        if (s1_move)
        begin
            out_reg           <= s1_reg;
            out_read_data_reg <= s1_reg.ram_read ? rdata : 8'd0;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.read_data          = out_read_data_reg;
    assign rsp.rom_address        = out_reg.rom_address;
    assign rsp.ram_enabled_status = out_reg.ram_enabled_status;
    assign rsp.ram_dirty          = out_reg.ram_dirty;

endmodule

>>> tb/cartridge_bank_mapper_checker.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [7:0]  read_data,
    input  logic [20:0] rom_address,
    input  logic        ram_enabled_status,
    input  logic        ram_dirty,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          pending
);
    import cbm_pkg::*;

    localparam int RAM_BANKS      = 4;
    localparam int ROM_LIMIT      = 128;
    localparam int BANK_BYTES     = 8192;
    localparam int ROM_BANK_BYTES = 16384;

    typedef struct packed {
        logic [7:0]  rd;
        logic [20:0] rom;
        logic        en;
        logic        dirty;
    } access_t;

    access_t mapper_q[$];
    access_t got;
    access_t want;

    logic       present;
    logic       ram_on;
    logic       mode;
    logic       dirty;
    logic [4:0] bank_lo;
    logic [1:0] bank_hi;
    logic [1:0] ram_sel;
    logic [6:0] rom_sel;
    logic [7:0] ram_bytes [0:RAM_BANKS*BANK_BYTES-1];

    function automatic void remap_banks();
        if (mode) begin
            rom_sel = {2'b00, bank_lo};
            ram_sel = bank_hi;
        end
        else begin
            rom_sel = {bank_hi, bank_lo};
            ram_sel = 2'd0;
        end
        // banks 0x00, 0x20, 0x40 and 0x60 step up by one
        if (rom_sel[4:0] == 5'd0)
            rom_sel = rom_sel + 7'd1;
    endfunction

    // The bank offset applies only while RAM is enabled
    function automatic logic [14:0] byte_slot(logic [15:0] a);
        int off;
        off = ram_on ? (int'(ram_sel) % RAM_BANKS) * BANK_BYTES : 0;
        return 15'(off + int'(a[12:0]));
    endfunction

    function automatic access_t serve_access(req_type_t kind, logic [15:0] a, logic [7:0] d);
        access_t r;
        int      bank;
        r = '0;
        case (kind)
            REQ_ROM_READ: begin
                bank = int'(rom_sel);
                if (bank > ROM_LIMIT - 1)
                    bank = ROM_LIMIT - 1;
                r.rom = 21'(int'(a) + (bank - 1) * ROM_BANK_BYTES);
            end
            REQ_RAM_READ: begin
                if (a[15:13] == REGION_RAM)
                    r.rd = ram_bytes[byte_slot(a)];
            end
            REQ_WRITE: begin
                case (a[15:13])
                    REGION_ENABLE:    ram_on = (d & ENABLE_MASK) != 8'd0;
                    REGION_BANK_LOW:  begin bank_lo = d[4:0]; remap_banks(); end
                    REGION_BANK_HIGH: begin bank_hi = d[1:0]; remap_banks(); end
                    REGION_MODE: begin
                        mode    = d != 8'd0;
                        bank_hi = 2'd0;
                        remap_banks();
                    end
                    REGION_RAM: begin
                        ram_bytes[byte_slot(a)] = d;
                        dirty = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.en    = ram_on & present;
        r.dirty = dirty;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            fail_count++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            present    = 1'b1;
            ram_on     = 1'b0;
            mode       = 1'b0;
            dirty      = 1'b0;
            bank_lo    = 5'd0;
            bank_hi    = 2'd0;
            ram_sel    = 2'd0;
            rom_sel    = 7'd1;
            fail_count = 0;
            mapper_q.delete();
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                present = cfg_data;
            if (req_valid && req_ready)
                mapper_q.push_back(serve_access(req_type_t'(req_kind), address, write_data));
            if (rsp_valid && rsp_ready) begin
                got = '{read_data, rom_address, ram_enabled_status, ram_dirty};
                if (mapper_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word: expected none, got 0x%0h", $time, got);
                end
                else begin
                    want = mapper_q.pop_front();
                    check_field("read_data", 32'(want.rd), 32'(got.rd));
                    check_field("rom_address", 32'(want.rom), 32'(got.rom));
                    check_field("ram_enabled_status", 32'(want.en), 32'(got.en));
                    check_field("ram_dirty", 32'(want.dirty), 32'(got.dirty));
                end
            end
            pending <= mapper_q.size();
        end
    end

endmodule

>>> tb/cartridge_bank_mapper_test.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_test;
    import cbm_pkg::*;

    // Generous ceiling on the length of a run
    localparam int CYCLE_LIMIT  = 250000;
    localparam int PHASE_WORDS  = 550;
    localparam int SETTLE_TICKS = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cbm_req_if req_ch ();
    cbm_rsp_if rsp_ch ();
    cbm_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Idle percentages for the sender and the receiver
    int send_idle = 0;
    int recv_idle = 0;

    // Stimulus-side view of the banking, just enough to know which store
    // byte a RAM read will hit, so that reads only land on written bytes
    logic       t_en   = 1'b0;
    logic       t_mode = 1'b0;
    logic [1:0] t_hi   = 2'd0;
    bit         written [0:32767];

    int words_sent   = 0;
    int stored_reads = 0;
    int ctrl_writes  = 0;

    always #10 clk = ~clk;

    cartridge_bank_mapper i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    cartridge_bank_mapper_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_ch.valid),
        .req_ready          (req_ch.ready),
        .req_kind           (req_ch.req_type),
        .address            (req_ch.address),
        .write_data         (req_ch.write_data),
        .rsp_valid          (rsp_ch.valid),
        .rsp_ready          (rsp_ch.ready),
        .read_data          (rsp_ch.read_data),
        .rom_address        (rsp_ch.rom_address),
        .ram_enabled_status (rsp_ch.ram_enabled_status),
        .ram_dirty          (rsp_ch.ram_dirty),
        .cfg_valid          (cfg_ch.valid),
        .cfg_ready          (cfg_ch.ready),
        .cfg_data           (cfg_ch.data),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // Stall the result side at the current rate
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Drop the run if it hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count, pending);
            $display("cartridge_bank_mapper_test: errors");
            $finish;
        end
    end

    function automatic logic [14:0] store_slot(logic [15:0] a);
        logic [1:0] bank;
        bank = (t_en && t_mode) ? t_hi : 2'd0;
        return {bank, a[12:0]};
    endfunction

    // Mostly a handful of offsets at both ends of the window, so that reads
    // find bytes written earlier; sometimes anywhere in the window
    function automatic logic [15:0] window_addr();
        case ($urandom_range(4))
            0, 1, 2: return 16'hA000 + 16'($urandom_range(15));
            3:       return 16'hBFF0 + 16'($urandom_range(15));
            default: return {REGION_RAM, 13'($urandom)};
        endcase
    endfunction

    // Wait until every word sent so far has come back. Advance first: a
    // word accepted at this edge is not counted yet.
    task automatic drain();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_present(input logic value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Send one bus word. A RAM read of a byte never written turns into a
    // write of that byte, so the read can come later.
    task automatic issue(input req_type_t kind, input logic [15:0] a, input logic [7:0] d);
        logic [14:0] slot;
        slot = store_slot(a);
        if (kind == REQ_RAM_READ && a[15:13] == REGION_RAM) begin
            if (!written[slot])
                kind = REQ_WRITE;
            else
                stored_reads++;
        end
        if (kind == REQ_WRITE) begin
            case (a[15:13])
                REGION_ENABLE:    t_en = (d & ENABLE_MASK) != 8'd0;
                REGION_BANK_HIGH: t_hi = d[1:0];
                REGION_MODE: begin
                    t_mode = d != 8'd0;
                    t_hi   = 2'd0;
                end
                REGION_RAM:       written[slot] = 1'b1;
                default: ;
            endcase
            if (a[15] == 1'b0)
                ctrl_writes++;
        end
        // Hold valid low for a random gap, then offer the word until taken
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.address    <= a;
        req_ch.write_data <= d;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
    endtask

    task automatic random_word();
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(99);
        d    = 8'($urandom);
        if (pick < 28) begin
            issue(REQ_ROM_READ, 16'($urandom), d);
        end
        else if (pick < 55) begin
            // a few reads fall outside the window and must return zero
            a = ($urandom_range(9) < 8) ? window_addr() : 16'($urandom);
            issue(REQ_RAM_READ, a, d);
        end
        else if (pick < 75) begin
            issue(REQ_WRITE, window_addr(), d);
        end
        else if (pick < 95) begin
            a = {3'($urandom_range(3)), 13'($urandom)};
            issue(REQ_WRITE, a, d);
        end
        else if (pick < 97) begin
            // writes the mapper must ignore: 0x8000-0x9FFF and 0xC000 up
            a = $urandom_range(1) ? {3'd4, 13'($urandom)}
                                  : {3'($urandom_range(7, 6)), 13'($urandom)};
            issue(REQ_WRITE, a, d);
        end
        else begin
            issue(REQ_NOP, 16'($urandom), d);
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input logic present);
        write_present(present);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < PHASE_WORDS; i++) begin
            // Halfway through, stop sending until the pipe is empty
            if (i == PHASE_WORDS / 2) begin
                req_ch.valid <= 1'b0;
                drain();
            end
            random_word();
        end
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_NOP;
        req_ch.address    = 16'd0;
        req_ch.write_data = 8'd0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: corners of the banking, with light stalls
        write_present(1'b1);
        send_idle = 20;
        recv_idle = 20;
        issue(REQ_ROM_READ, 16'h4000, 8'h00);   // reset bank 1
        issue(REQ_ROM_READ, 16'h0000, 8'hFF);
        issue(REQ_WRITE,    16'h0000, 8'h0A);   // enable RAM
        issue(REQ_WRITE,    16'hA000, 8'hFF);
        issue(REQ_RAM_READ, 16'hA000, 8'h00);
        issue(REQ_RAM_READ, 16'h9FFF, 8'h00);   // read below the window
        issue(REQ_WRITE,    16'h2000, 8'h00);   // low bank 0 steps to 1
        issue(REQ_WRITE,    16'h3FFF, 8'h1F);
        issue(REQ_WRITE,    16'h4000, 8'h03);   // bank 0x7F, the top
        issue(REQ_ROM_READ, 16'hFFFF, 8'h00);   // ROM address wraps at 21 bits
        issue(REQ_WRITE,    16'h2000, 8'h00);   // 0x60 steps to 0x61
        issue(REQ_ROM_READ, 16'h7FFF, 8'h00);
        issue(REQ_WRITE,    16'h6000, 8'h01);   // mode 1 also clears the high bank
        issue(REQ_WRITE,    16'h5FFF, 8'h02);   // RAM bank 2
        issue(REQ_WRITE,    16'hBFFF, 8'h5A);
        issue(REQ_RAM_READ, 16'hBFFF, 8'h00);
        issue(REQ_WRITE,    16'h1FFF, 8'hF5);   // no bit of the enable mask: off
        issue(REQ_WRITE,    16'hBFFF, 8'hA5);   // disabled write goes to bank 0
        issue(REQ_RAM_READ, 16'hBFFF, 8'h00);
        issue(REQ_WRITE,    16'h8000, 8'hFF);   // ignored
        issue(REQ_WRITE,    16'hFFFF, 8'h00);   // ignored
        issue(REQ_NOP,      16'hFFFF, 8'hFF);
        issue(REQ_WRITE,    16'h7FFF, 8'h00);   // back to mode 0
        issue(REQ_WRITE,    16'h0000, 8'h08);   // one mask bit is enough
        issue(REQ_RAM_READ, 16'hA000, 8'h00);
        req_ch.valid <= 1'b0;

        // Random part: slow receiver, then slow sender, then full rate
        run_phase(33, 86, 1'b0);
        run_phase(86, 33, 1'b1);
        run_phase(0, 0, 1'b0);

        drain();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("covered %0d bus words, %0d control writes, %0d RAM reads of stored bytes",
                 words_sent, ctrl_writes, stored_reads);
        $display("under slow-sink, slow-source and full-rate traffic, RAM present off and on");
        if (fail_count == 0)
            $display("cartridge_bank_mapper_test: clean");
        else
            $display("cartridge_bank_mapper_test: errors");
        $finish;
    end

endmodule
